[rtl/classfile_constant_pool_parser_top_assert.svh]
// Assertion macros for the constant pool parser checker.
`ifndef CLASSFILE_CONSTANT_POOL_PARSER_TOP_ASSERT_SVH
`define CLASSFILE_CONSTANT_POOL_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CPOOL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CPOOL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cpool_pkg.sv]
// Tag codes, status codes and entry layout tables for the constant pool parser.
package cpool_pkg;

  localparam int unsigned ADDR_W = 3;

  localparam logic [7:0] TAG_UTF8         = 8'd1;
  localparam logic [7:0] TAG_INTEGER      = 8'd3;
  localparam logic [7:0] TAG_FLOAT        = 8'd4;
  localparam logic [7:0] TAG_LONG         = 8'd5;
  localparam logic [7:0] TAG_DOUBLE       = 8'd6;
  localparam logic [7:0] TAG_CLASS        = 8'd7;
  localparam logic [7:0] TAG_STRING       = 8'd8;
  localparam logic [7:0] TAG_FIELDREF     = 8'd9;
  localparam logic [7:0] TAG_METHODREF    = 8'd10;
  localparam logic [7:0] TAG_IMETHODREF   = 8'd11;
  localparam logic [7:0] TAG_NAMEANDTYPE  = 8'd12;
  localparam logic [7:0] TAG_METHODHANDLE = 8'd15;
  localparam logic [7:0] TAG_METHODTYPE   = 8'd16;
  localparam logic [7:0] TAG_INVOKEDYN    = 8'd18;

  localparam logic [0:0] REG_POOL_COUNT = 1'b0;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_UNKNOWN_TAG = 2'd1,
    STATUS_AFTER_DONE  = 2'd2
  } status_t;

  // Field bytes that follow the tag; zero for an unknown tag.
  function automatic logic [3:0] kind_total(input logic [7:0] t);
    logic [3:0] n;
    case (t) inside
      TAG_CLASS, TAG_STRING, TAG_METHODTYPE, TAG_UTF8: n = 4'd2;
      TAG_FIELDREF, TAG_METHODREF, TAG_IMETHODREF, TAG_NAMEANDTYPE,
      TAG_INVOKEDYN, TAG_INTEGER, TAG_FLOAT: n = 4'd4;
      TAG_LONG, TAG_DOUBLE: n = 4'd8;
      TAG_METHODHANDLE: n = 4'd3;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // Field bytes that land in the first word.
  function automatic logic [3:0] kind_first(input logic [7:0] t);
    logic [3:0] n;
    case (t) inside
      TAG_INTEGER, TAG_FLOAT, TAG_LONG, TAG_DOUBLE: n = 4'd4;
      TAG_METHODHANDLE: n = 4'd1;
      default: n = 4'd2;
    endcase
    return n;
  endfunction

endpackage

[rtl/classfile_constant_pool_parser_top.sv]
// Constant pool parser: decodes class file pool bytes into one record per entry,
// unknown tag or byte past the pool's end. It takes one pool byte per cycle while
// the result register is empty or being drained, with no gaps between entries or
// pools. Each byte is decoded in a single registered pass: the entry state (tag,
// remaining bytes, field words, slot and offset) and the result register are both
// updated at the edge that accepts the byte, so a record appears on the master
// side in the cycle after the byte that produces it.
// Utf8 string bytes are consumed at the same rate with no record.
module classfile_constant_pool_parser_top (
  input  logic                            clk,
  input  logic                            rst,
  // slave stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] data_byte
  input  logic [0:0]                      s_tuser,   // [0] pool_start
  // master stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [15:0] entry_index, [23:16] entry_tag, [55:24] field_first, [87:56] field_second
  output logic [87:0]                     m_tdata,
  output logic [1:0]                      m_tuser,   // [1:0] status
  output logic                            m_tlast,   // pool_done
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cpool_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [15:0] pool_count;

  logic        in_entry, in_entry_next;
  logic        in_string, in_string_next;
  logic [7:0]  current_tag, current_tag_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [31:0] accum_first, accum_first_next;
  logic [31:0] accum_second, accum_second_next;
  logic [15:0] slot_counter, slot_counter_next;
  logic [31:0] byte_offset, byte_offset_next;
  logic        pool_finished, pool_finished_next;

  logic                 emit;
  logic [15:0]          res_index;
  logic [7:0]           res_tag;
  logic [31:0]          res_first;
  logic [31:0]          res_second;
  cpool_pkg::status_t   res_status;
  logic                 res_done;

  logic        s_fire;
  logic        start;
  logic [7:0]  b;
  logic        cfg_write;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[cpool_pkg::ADDR_W-1] == cpool_pkg::REG_POOL_COUNT);
  assign prdata    = (paddr[cpool_pkg::ADDR_W-1] == cpool_pkg::REG_POOL_COUNT) ?
                     {16'd0, pool_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_count <= 16'd1;
    end else if (cfg_write) begin
      pool_count <= pwdata[15:0];
    end
  end

  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;
  assign start    = s_tuser[0];
  assign b        = s_tdata;

  always_comb begin
    logic [31:0] cur;
    logic [3:0]  total;
    logic [3:0]  k;
    logic        finish;
    logic [16:0] next_slot;

    in_entry_next      = in_entry;
    in_string_next     = in_string;
    current_tag_next   = current_tag;
    bytes_left_next    = bytes_left;
    accum_first_next   = accum_first;
    accum_second_next  = accum_second;
    slot_counter_next  = slot_counter;
    pool_finished_next = pool_finished;
    emit       = 1'b0;
    finish     = 1'b0;
    res_index  = 16'd0;
    res_tag    = b;
    res_first  = 32'd0;
    res_second = 32'd0;
    res_status = cpool_pkg::STATUS_OK;
    res_done   = 1'b0;
    next_slot  = 17'd0;
    total      = 4'd0;
    k          = 4'd0;

    // a new pool drops any entry in progress
    if (start) begin
      cur                = 32'd0;
      slot_counter_next  = 16'd1;
      in_entry_next      = 1'b0;
      in_string_next     = 1'b0;
      pool_finished_next = 1'b0;
      bytes_left_next    = 16'd0;
      accum_first_next   = 32'd0;
      accum_second_next  = 32'd0;
    end else begin
      cur = byte_offset;
    end
    byte_offset_next = cur + 32'd1;

    if (!in_entry_next) begin
      if (pool_finished_next || slot_counter_next >= pool_count) begin
        emit       = 1'b1;
        res_status = cpool_pkg::STATUS_AFTER_DONE;
      end else begin
        total = cpool_pkg::kind_total(b);
        if (total == 4'd0) begin
          emit       = 1'b1;
          res_index  = slot_counter_next;
          res_status = cpool_pkg::STATUS_UNKNOWN_TAG;
        end else begin
          current_tag_next  = b;
          bytes_left_next   = {12'd0, total};
          accum_first_next  = 32'd0;
          accum_second_next = 32'd0;
          in_entry_next     = 1'b1;
          in_string_next    = 1'b0;
        end
      end
    end else if (in_string) begin
      bytes_left_next = bytes_left - 16'd1;
      finish          = (bytes_left_next == 16'd0);
    end else begin
      total = cpool_pkg::kind_total(current_tag);
      k     = total - bytes_left[3:0];
      if (k < cpool_pkg::kind_first(current_tag)) begin
        accum_first_next = {accum_first[23:0], b};
      end else begin
        accum_second_next = {accum_second[23:0], b};
      end
      bytes_left_next = bytes_left - 16'd1;
      if (bytes_left_next == 16'd0) begin
        if (current_tag == cpool_pkg::TAG_UTF8) begin
          // offset of the first string byte
          accum_second_next = cur + 32'd1;
          if (accum_first_next[15:0] == 16'd0) begin
            finish = 1'b1;
          end else begin
            in_string_next  = 1'b1;
            bytes_left_next = accum_first_next[15:0];
          end
        end else begin
          finish = 1'b1;
        end
      end
    end

    if (finish) begin
      next_slot = {1'b0, slot_counter}
                + ((current_tag == cpool_pkg::TAG_LONG || current_tag == cpool_pkg::TAG_DOUBLE)
                   ? 17'd2 : 17'd1);
      emit       = 1'b1;
      res_index  = slot_counter;
      res_tag    = current_tag;
      res_first  = accum_first_next;
      res_second = accum_second_next;
      res_done   = (next_slot >= {1'b0, pool_count});
      slot_counter_next = next_slot[15:0];
      if (res_done) begin
        pool_finished_next = 1'b1;
      end
      in_entry_next   = 1'b0;
      in_string_next  = 1'b0;
      bytes_left_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_entry      <= 1'b0;
      in_string     <= 1'b0;
      current_tag   <= 8'd0;
      bytes_left    <= 16'd0;
      accum_first   <= 32'd0;
      accum_second  <= 32'd0;
      slot_counter  <= 16'd1;
      byte_offset   <= 32'd0;
      pool_finished <= 1'b0;
    end else if (s_fire) begin
      in_entry      <= in_entry_next;
      in_string     <= in_string_next;
      current_tag   <= current_tag_next;
      bytes_left    <= bytes_left_next;
      accum_first   <= accum_first_next;
      accum_second  <= accum_second_next;
      slot_counter  <= slot_counter_next;
      byte_offset   <= byte_offset_next;
      pool_finished <= pool_finished_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && emit) begin
      m_tdata <= {res_second, res_first, res_tag, res_index};
      m_tuser <= res_status;
      m_tlast <= res_done;
    end
  end

endmodule

[rtl/cpool_checker.sv]
// Port-level checker for the constant pool parser, bound to the top level.
`include "classfile_constant_pool_parser_top_assert.svh"

module cpool_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  `CPOOL_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled record changed")
  `CPOOL_ASSERT_NOW(a_take_when_empty, clk, rst, !m_tvalid, s_tready, "input stalled with empty result register")
  `CPOOL_ASSERT_NOW(a_error_not_last, clk, rst, m_tvalid && (m_tuser != cpool_pkg::STATUS_OK), !m_tlast, "error record marks pool done")
  `CPOOL_ASSERT_NOW(a_after_done_fields, clk, rst, m_tvalid && (m_tuser == cpool_pkg::STATUS_AFTER_DONE), m_tdata[15:0] == 16'd0 && m_tdata[87:24] == 64'd0, "late byte record carries slot or fields")
  `CPOOL_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !m_tvalid, "record present right after reset")

endmodule

bind classfile_constant_pool_parser_top cpool_checker u_cpool_checker (.*);

[tb/classfile_constant_pool_parser_top_tb.sv]
// Self-checking testbench for the constant pool parser: random pools against a local decoder.
module classfile_constant_pool_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [7:0] s_tdata;   // [7:0] data_byte
  logic [0:0] s_tuser;   // [0] pool_start
  logic m_tvalid;
  logic m_tready;
  // [15:0] entry_index, [23:16] entry_tag, [55:24] field_first, [87:56] field_second
  logic [87:0] m_tdata;
  logic [1:0] m_tuser;   // [1:0] status
  logic m_tlast;
  logic psel;
  logic penable;
  logic pwrite;
  logic [cpool_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bit quiet = 1'b0;
  int idle_cycles = 0;

  typedef struct {
    logic [15:0] index;
    logic [7:0] tag;
    logic [31:0] first;
    logic [31:0] second;
    cpool_pkg::status_t status;
    logic done;
  } pool_record_t;

  // Decodes the byte stream on its own and holds the records still to come.
  class entry_tracker;
    pool_record_t expected_records[$];
    logic [15:0] pool_count;
    bit in_entry;
    bit in_string;
    logic [7:0] tag;
    logic [15:0] bytes_left;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [15:0] slot;
    logic [31:0] next_offset;
    bit finished;
    int bytes_in;
    int entries_ok;
    int unknown_tags;
    int late_bytes;
    int pools_done;
    int failures;

    function new();
      pool_count = 16'd1;
      in_entry = 1'b0;
      in_string = 1'b0;
      tag = 8'd0;
      bytes_left = 16'd0;
      first_word = 32'd0;
      second_word = 32'd0;
      slot = 16'd1;
      next_offset = 32'd0;
      finished = 1'b0;
      bytes_in = 0;
      entries_ok = 0;
      unknown_tags = 0;
      late_bytes = 0;
      pools_done = 0;
      failures = 0;
    endfunction

    static function int unsigned field_bytes(logic [7:0] t);
      case (t)
        cpool_pkg::TAG_CLASS, cpool_pkg::TAG_STRING, cpool_pkg::TAG_METHODTYPE,
        cpool_pkg::TAG_UTF8: return 2;
        cpool_pkg::TAG_FIELDREF, cpool_pkg::TAG_METHODREF, cpool_pkg::TAG_IMETHODREF,
        cpool_pkg::TAG_NAMEANDTYPE, cpool_pkg::TAG_INVOKEDYN,
        cpool_pkg::TAG_INTEGER, cpool_pkg::TAG_FLOAT: return 4;
        cpool_pkg::TAG_LONG, cpool_pkg::TAG_DOUBLE: return 8;
        cpool_pkg::TAG_METHODHANDLE: return 3;
        default: return 0;
      endcase
    endfunction

    static function int unsigned first_word_bytes(logic [7:0] t);
      case (t)
        cpool_pkg::TAG_INTEGER, cpool_pkg::TAG_FLOAT, cpool_pkg::TAG_LONG,
        cpool_pkg::TAG_DOUBLE: return 4;
        cpool_pkg::TAG_METHODHANDLE: return 1;
        default: return 2;
      endcase
    endfunction

    function void expect_record(logic [15:0] idx, logic [7:0] t, logic [31:0] f1,
                                logic [31:0] f2, cpool_pkg::status_t st, logic done);
      pool_record_t r;
      r.index = idx;
      r.tag = t;
      r.first = f1;
      r.second = f2;
      r.status = st;
      r.done = done;
      expected_records.push_back(r);
    endfunction

    function void close_entry();
      int unsigned after_slot;
      after_slot = slot + ((tag == cpool_pkg::TAG_LONG || tag == cpool_pkg::TAG_DOUBLE) ? 2 : 1);
      expect_record(slot, tag, first_word, second_word, cpool_pkg::STATUS_OK,
                    after_slot >= pool_count);
      slot = 16'(after_slot);
      if (after_slot >= pool_count) finished = 1'b1;
      in_entry = 1'b0;
      in_string = 1'b0;
      bytes_left = 16'd0;
    endfunction

    function void take_byte(logic [7:0] b, bit start);
      logic [31:0] pos;
      int unsigned total;
      int unsigned k;
      bytes_in++;
      if (start) begin
        pos = 32'd0;
        slot = 16'd1;
        in_entry = 1'b0;
        in_string = 1'b0;
        finished = 1'b0;
        bytes_left = 16'd0;
        first_word = 32'd0;
        second_word = 32'd0;
      end else begin
        pos = next_offset;
      end
      next_offset = pos + 32'd1;

      if (!in_entry) begin
        if (finished || slot >= pool_count) begin
          expect_record(16'd0, b, 32'd0, 32'd0, cpool_pkg::STATUS_AFTER_DONE, 1'b0);
          return;
        end
        total = field_bytes(b);
        if (total == 0) begin
          expect_record(slot, b, 32'd0, 32'd0, cpool_pkg::STATUS_UNKNOWN_TAG, 1'b0);
          return;
        end
        tag = b;
        bytes_left = 16'(total);
        first_word = 32'd0;
        second_word = 32'd0;
        in_entry = 1'b1;
        in_string = 1'b0;
        return;
      end

      // string body: counted, never reported
      if (in_string) begin
        bytes_left = bytes_left - 16'd1;
        if (bytes_left == 16'd0) close_entry();
        return;
      end

      k = field_bytes(tag) - bytes_left;
      if (k < first_word_bytes(tag)) first_word = {first_word[23:0], b};
      else second_word = {second_word[23:0], b};
      bytes_left = bytes_left - 16'd1;
      if (bytes_left != 16'd0) return;
      if (tag == cpool_pkg::TAG_UTF8) begin
        second_word = pos + 32'd1;
        if (first_word[15:0] == 16'd0) begin
          close_entry();
        end else begin
          in_string = 1'b1;
          bytes_left = first_word[15:0];
        end
        return;
      end
      close_entry();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void match_record(logic [87:0] data, logic [1:0] user, logic last);
      pool_record_t r;
      if (expected_records.size() == 0) begin
        $error("unexpected record: tag 0x%0h status %0d", data[23:16], user);
        failures++;
        return;
      end
      r = expected_records.pop_front();
      compare_field("entry_index", r.index, data[15:0]);
      compare_field("entry_tag", r.tag, data[23:16]);
      compare_field("field_first", r.first, data[55:24]);
      compare_field("field_second", r.second, data[87:56]);
      compare_field("status", r.status, user);
      compare_field("pool_done", r.done, last);
      case (r.status)
        cpool_pkg::STATUS_OK: entries_ok++;
        cpool_pkg::STATUS_UNKNOWN_TAG: unknown_tags++;
        default: late_bytes++;
      endcase
      if (r.done) pools_done++;
    endfunction
  endclass

  entry_tracker tracker = new();

  classfile_constant_pool_parser_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output side: random stall bursts, none once quiet is set.
  initial begin
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 8);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.match_record(m_tdata, m_tuser, m_tlast);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit start);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_byte(b, start);
    @(negedge clk);
  endtask

  // Rare restart inside an entry when the field bytes are random.
  function automatic bit break_here(input int fill);
    return fill < 0 && $urandom_range(0, 199) == 0;
  endfunction

  function automatic logic [7:0] fill_byte(input int fill);
    return (fill < 0) ? 8'($urandom) : 8'(fill);
  endfunction

  // fill < 0 gives random field bytes, else every field byte is fill.
  task automatic send_entry(input logic [7:0] t, input bit start, input int fill,
                            input logic [15:0] str_len);
    send_byte(t, start);
    if (t == cpool_pkg::TAG_UTF8) begin
      send_byte(str_len[15:8], break_here(fill));
      send_byte(str_len[7:0], break_here(fill));
      repeat (str_len) send_byte(fill_byte(fill), break_here(fill));
    end else begin
      repeat (entry_tracker::field_bytes(t)) send_byte(fill_byte(fill), break_here(fill));
    end
  endtask

  function automatic logic [7:0] random_kind();
    case ($urandom_range(0, 13))
      0: return cpool_pkg::TAG_UTF8;
      1: return cpool_pkg::TAG_INTEGER;
      2: return cpool_pkg::TAG_FLOAT;
      3: return cpool_pkg::TAG_LONG;
      4: return cpool_pkg::TAG_DOUBLE;
      5: return cpool_pkg::TAG_CLASS;
      6: return cpool_pkg::TAG_STRING;
      7: return cpool_pkg::TAG_FIELDREF;
      8: return cpool_pkg::TAG_METHODREF;
      9: return cpool_pkg::TAG_IMETHODREF;
      10: return cpool_pkg::TAG_NAMEANDTYPE;
      11: return cpool_pkg::TAG_METHODHANDLE;
      12: return cpool_pkg::TAG_METHODTYPE;
      default: return cpool_pkg::TAG_INVOKEDYN;
    endcase
  endfunction

  function automatic logic [7:0] random_unknown();
    logic [7:0] b;
    b = 8'($urandom);
    while (entry_tracker::field_bytes(b) != 0) b = 8'($urandom);
    return b;
  endfunction

  // One pool opened by pool_start; small counts also get bytes past the last slot.
  task automatic send_pool(input logic [15:0] count);
    int unsigned entries;
    int unsigned r;
    logic [15:0] str_len;
    entries = (count > 40) ? $urandom_range(5, 30) : $urandom_range(1, int'(count) + 1);
    for (int i = 0; i < int'(entries); i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_byte(random_unknown(), i == 0);
      end else if (r < 8) begin
        send_byte(8'($urandom), i == 0);
      end else begin
        str_len = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 8))
                                             : 16'($urandom_range(9, 60));
        send_entry(random_kind(), i == 0, -1, str_len);
      end
    end
  endtask

  task automatic write_pool_count(input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {cpool_pkg::REG_POOL_COUNT, 2'b00};
    pwdata <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.pool_count = value;
  endtask

  // Hold off input until every outstanding record is back, then let the pipe settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_records.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] count;
    int target;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'd0;
    s_tuser = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 32'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // count of one after reset: every tag lands past the end
    send_byte(cpool_pkg::TAG_CLASS, 1'b1);
    drain_results();
    write_pool_count(16'd3);
    send_entry(cpool_pkg::TAG_UTF8, 1'b1, 0, 16'd0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_entry(cpool_pkg::TAG_DOUBLE, 1'b0, 8'hFF, 16'd0);  // two slots, ends the pool
    send_byte(cpool_pkg::TAG_STRING, 1'b0);
    send_entry(cpool_pkg::TAG_METHODHANDLE, 1'b1, 0, 16'd0);
    send_entry(cpool_pkg::TAG_INVOKEDYN, 1'b0, 8'hFF, 16'd0);

    for (int p = 0; p < 10; p++) begin
      drain_results();
      case (p)
        0: count = 16'hFFFF;
        1: count = 16'd1;
        default: count = 16'($urandom_range(2, 24));
      endcase
      if (p == 9) quiet = 1'b1;
      write_pool_count(count);
      target = tracker.bytes_in + ((count == 16'd1) ? 40 : 130);
      while (tracker.bytes_in < target) send_pool(count);
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("sent %0d pool bytes over 10 count settings, with restarts and noise",
             tracker.bytes_in);
    $display("records: %0d entries, %0d unknown tags, %0d past end, %0d pools filled",
             tracker.entries_ok, tracker.unknown_tags, tracker.late_bytes, tracker.pools_done);
    if (tracker.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
